### rtl/core/time_window_condition_detector_unit_defines.svh
// assertion macros for the time window condition detector
// no dependencies; included by the files that check their own logic
`ifndef TIME_WINDOW_CONDITION_DETECTOR_UNIT_DEFINES_SVH
`define TIME_WINDOW_CONDITION_DETECTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TWCD_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("twcd check failed");
`define TWCD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("twcd check failed");
`define TWCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("twcd check failed");
`else
`define TWCD_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define TWCD_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define TWCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/core/twcd_pkg.sv
// shared constants, types and helpers for the time window condition detector
// no dependencies
package twcd_pkg;

    localparam int unsigned DEPTH     = 64;
    localparam int unsigned AW        = $clog2(DEPTH);
    localparam int unsigned CW        = $clog2(DEPTH + 1);
    localparam int unsigned PW        = CW + 7;
    localparam int unsigned CNTX_W    = (CW > 7) ? CW : 7;

    localparam int unsigned VAL_W     = 32;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned ENTRY_W   = VAL_W + TIME_W;
    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned OUT_BITS  = 2 + 1 + 7 + 7 + 32;
    localparam int unsigned M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int unsigned PAD_W     = M_TDATA_W - OUT_BITS;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [31:0] RST_MIN_GAP   = 32'd1000;
    localparam logic [31:0] RST_WINDOW    = 32'd1000000;
    localparam logic [6:0]  RST_MIN_COUNT = 7'd2;
    localparam logic [1:0]  RST_UNIT      = 2'd2;
    localparam logic [6:0]  RST_PCT       = 7'd50;

    localparam logic [19:0] SCALE_SEC  = 20'd1000000;
    localparam logic [19:0] SCALE_MSEC = 20'd1000;
    localparam logic [19:0] SCALE_USEC = 20'd1;
    localparam logic [6:0]  PCT_SCALE  = 7'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_GAP   = 3'd0,
        REG_WINDOW    = 3'd1,
        REG_MIN_COUNT = 3'd2,
        REG_KIND      = 3'd3,
        REG_REL       = 3'd4,
        REG_THR       = 3'd5,
        REG_UNIT      = 3'd6,
        REG_PCT       = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        UNIT_USEC = 2'd0,
        UNIT_MSEC = 2'd1,
        UNIT_SEC  = 2'd2
    } t_unit;

    typedef enum logic [1:0] {
        ST_STORED   = 2'd0,
        ST_TOO_SOON = 2'd1,
        ST_CLEARED  = 2'd2
    } t_status;

    typedef struct packed {
        logic [TIME_W-1:0]       time_us;
        logic signed [VAL_W-1:0] value;
    } t_entry;

    function automatic logic [19:0] unit_scale(logic [1:0] unit);
        logic [19:0] s;
        case (unit)
            UNIT_SEC:  s = SCALE_SEC;
            UNIT_MSEC: s = SCALE_MSEC;
            default:   s = SCALE_USEC;
        endcase
        return s;
    endfunction

    function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW + 1)'(base) + (CW + 1)'(off);
        if (s >= (CW + 1)'(DEPTH)) begin
            s = s - (CW + 1)'(DEPTH);
        end
        return AW'(s);
    endfunction

endpackage

### rtl/core/twcd_ram.sv
// generic single write port ram with registered read
// no dependencies
module twcd_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/time_window_condition_detector_unit.sv
// Sequence: a rejected or clearing item goes from the gap check to its result; a stored one
// is pushed and applied, entries older than the window are trimmed and the span updated; a
// full ring drops its oldest entry first. In slope mode a push (not the first) and each drop
// add the slope steps. One item at a time, set by the single ring read port and the shared
// 33x33 multiplier; a result still waiting at the output holds the last step.
// Reset (synchronous, active low) empties the window and loads the default configuration.
// top level time window condition detector: ring store, sequencer, shared multiplier
// depends on twcd_pkg, twcd_ram and the assertion macro header
`include "time_window_condition_detector_unit_defines.svh"

module time_window_condition_detector_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [twcd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [twcd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // sample_value[31:0], sample_time_us[63:32]
    input  logic [twcd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status[1:0], condition_met[2], sample_count[9:3], pass_count[16:10], span_us[48:17]
    output logic [twcd_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    import twcd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GAP,
        S_DRD,
        S_PUSH,
        S_PD,
        S_PM1,
        S_PM2,
        S_PC,
        S_APPLY,
        S_TRIM,
        S_TRD,
        S_SPAN,
        S_DONE
    } t_state;

    t_state r_state, r_ret;

    // configuration
    logic [31:0]        r_min_gap, r_window;
    logic [6:0]         r_min_count, r_pct;
    logic               r_kind, r_rel;
    logic signed [31:0] r_thr;
    logic [1:0]         r_unit;

    // window state
    logic [AW-1:0]      r_ptr;
    logic [CW-1:0]      r_held, r_passing;
    logic [31:0]        r_span;
    logic signed [31:0] r_new_v, r_old_v, r_in_v, r_a_v, r_b_v;
    logic [31:0]        r_new_t, r_old_t, r_in_t, r_a_t, r_b_t;
    t_status            r_status;
    logic               r_is_drop, r_hit;

    // slope datapath
    logic signed [32:0] r_dv;
    logic [31:0]        r_dt;
    logic signed [63:0] r_lhs, r_rhs;
    logic signed [32:0] mul_x, mul_y;
    logic signed [65:0] mul_p;

    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;

    logic [AW-1:0]      ptr_plus1, wr_addr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd_entry, wr_entry;
    logic               ram_we;
    logic [31:0]        gap, trim_diff;
    logic               in_hit, old_hit, pair_hit;
    logic [CW-1:0]      denom;
    logic [PW-1:0]      pass_scaled, need_scaled;
    logic               cond;

    assign ptr_plus1 = ring_add(r_ptr, CW'(1));
    assign wr_addr   = ring_add(r_ptr, r_held);
    assign ram_we    = (r_state == S_PUSH);
    assign wr_entry  = '{time_us: r_in_t, value: r_in_v};
    assign rd_entry  = t_entry'(ram_rdata);

    twcd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_addr (ptr_plus1),
        .o_rd_data (ram_rdata)
    );

    assign gap       = r_in_t - r_new_t;
    assign trim_diff = r_new_t - rd_entry.time_us;
    assign in_hit    = r_rel ? (r_in_v < r_thr) : (r_in_v > r_thr);
    assign old_hit   = r_rel ? (r_old_v < r_thr) : (r_old_v > r_thr);
    assign pair_hit  = r_rel ? (r_lhs < r_rhs) : (r_lhs > r_rhs);

    // one shared multiplier: dv * scale, then threshold * dt
    always_comb begin
        if (r_state == S_PM1) begin
            mul_x = r_dv;
            mul_y = $signed({13'd0, unit_scale(r_unit)});
        end else begin
            mul_x = 33'(r_thr);
            mul_y = $signed({1'b0, r_dt});
        end
    end
    assign mul_p = mul_x * mul_y;

    // pass ratio test
    always_comb begin
        denom       = r_kind ? (r_held - CW'(1)) : r_held;
        pass_scaled = PW'(r_passing) * PW'(PCT_SCALE);
        need_scaled = PW'(r_pct) * PW'(denom);
        cond = (CNTX_W'(r_held) >= CNTX_W'(r_min_count))
            && (r_span >= r_window)
            && (r_kind ? (r_held >= CW'(2)) : (r_held != '0))
            && (pass_scaled >= need_scaled);
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_min_gap   <= RST_MIN_GAP;
            r_window    <= RST_WINDOW;
            r_min_count <= RST_MIN_COUNT;
            r_kind      <= 1'b0;
            r_rel       <= 1'b0;
            r_thr       <= '0;
            r_unit      <= RST_UNIT;
            r_pct       <= RST_PCT;
            r_ptr       <= '0;
            r_held      <= '0;
            r_passing   <= '0;
            r_span      <= '0;
            r_m_valid   <= 1'b0;
            r_status    <= ST_STORED;
            r_is_drop   <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_MIN_GAP:   r_min_gap   <= i_cfg_wdata;
                    REG_WINDOW:    r_window    <= i_cfg_wdata;
                    REG_MIN_COUNT: r_min_count <= i_cfg_wdata[6:0];
                    REG_KIND:      r_kind      <= i_cfg_wdata[0];
                    REG_REL:       r_rel       <= i_cfg_wdata[0];
                    REG_THR:       r_thr       <= $signed(i_cfg_wdata);
                    REG_UNIT:      r_unit      <= i_cfg_wdata[1:0];
                    REG_PCT:       r_pct       <= i_cfg_wdata[6:0];
                    default: ;
                endcase
            end

            if (r_m_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_in_v   <= $signed(s_axis_tdata[31:0]);
                        r_in_t   <= s_axis_tdata[63:32];
                        r_status <= ST_STORED;
                        r_state  <= S_GAP;
                    end
                end
                S_GAP: begin
                    if (r_held == '0) begin
                        r_state <= S_PUSH;
                    end else if (gap < r_min_gap) begin
                        r_status <= ST_TOO_SOON;
                        r_state  <= S_DONE;
                    end else if (gap > r_window) begin
                        r_status  <= ST_CLEARED;
                        r_held    <= '0;
                        r_passing <= '0;
                        r_span    <= '0;
                        r_state   <= S_DONE;
                    end else if (r_held == CW'(DEPTH)) begin
                        r_ret   <= S_PUSH;
                        r_state <= S_DRD;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_DRD: begin
                    // ring read of the second oldest entry is valid here
                    r_a_v     <= r_old_v;
                    r_a_t     <= r_old_t;
                    r_b_v     <= rd_entry.value;
                    r_b_t     <= rd_entry.time_us;
                    r_is_drop <= 1'b1;
                    r_hit     <= old_hit;
                    r_state   <= r_kind ? S_PD : S_APPLY;
                end
                S_PUSH: begin
                    r_held    <= r_held + CW'(1);
                    r_new_v   <= r_in_v;
                    r_new_t   <= r_in_t;
                    if (r_held == '0) begin
                        r_old_v <= r_in_v;
                        r_old_t <= r_in_t;
                    end
                    r_a_v     <= r_new_v;
                    r_a_t     <= r_new_t;
                    r_b_v     <= r_in_v;
                    r_b_t     <= r_in_t;
                    r_is_drop <= 1'b0;
                    r_ret     <= S_TRIM;
                    if (r_kind) begin
                        r_hit   <= 1'b0;
                        r_state <= (r_held != '0) ? S_PD : S_APPLY;
                    end else begin
                        r_hit   <= in_hit;
                        r_state <= S_APPLY;
                    end
                end
                S_PD: begin
                    r_dv    <= 33'(r_b_v) - 33'(r_a_v);
                    r_dt    <= r_b_t - r_a_t;
                    r_state <= S_PM1;
                end
                S_PM1: begin
                    r_lhs   <= 64'(mul_p);
                    r_state <= S_PM2;
                end
                S_PM2: begin
                    r_rhs   <= 64'(mul_p);
                    r_state <= S_PC;
                end
                S_PC: begin
                    r_hit   <= pair_hit;
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (r_is_drop) begin
                        if (r_hit && (r_passing != '0)) begin
                            r_passing <= r_passing - CW'(1);
                        end
                        r_ptr   <= ptr_plus1;
                        r_held  <= r_held - CW'(1);
                        r_old_v <= r_b_v;
                        r_old_t <= r_b_t;
                    end else if (r_hit) begin
                        r_passing <= r_passing + CW'(1);
                    end
                    r_state <= r_ret;
                end
                S_TRIM: begin
                    r_state <= (r_held >= CW'(2)) ? S_TRD : S_SPAN;
                end
                S_TRD: begin
                    if (trim_diff > r_window) begin
                        r_a_v     <= r_old_v;
                        r_a_t     <= r_old_t;
                        r_b_v     <= rd_entry.value;
                        r_b_t     <= rd_entry.time_us;
                        r_is_drop <= 1'b1;
                        r_hit     <= old_hit;
                        r_ret     <= S_TRIM;
                        r_state   <= r_kind ? S_PD : S_APPLY;
                    end else begin
                        r_state <= S_SPAN;
                    end
                end
                S_SPAN: begin
                    r_span  <= r_new_t - r_old_t;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {PAD_W'(0), r_span, 7'(r_passing), 7'(r_held),
                                      cond, r_status};
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TWCD_ASSERT_ALWAYS(a_held_bound, i_clk, i_rst_n, r_held <= CW'(DEPTH))
    `TWCD_ASSERT_IMPL(a_push_room, i_clk, i_rst_n, r_state == S_PUSH, r_held < CW'(DEPTH))
    `TWCD_ASSERT_IMPL(a_drop_pair, i_clk, i_rst_n, r_state == S_APPLY && r_is_drop, r_held >= CW'(2))
    `TWCD_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule
